// File: rtl/swec_pkg.sv
// Shared types and codes for the sliding-window event counter.
// Operation codes and the bucket word layout. No dependencies.
package swec_pkg;

    localparam int TENANT_W   = 7;
    localparam int TENANT_SPAN = 2 ** TENANT_W;
    localparam int COUNT_W    = 32;

    typedef enum logic [1:0] {
        OP_TASK   = 2'd0,
        OP_ESC    = 2'd1,
        OP_QUERY  = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // one bucket word: both counters side by side
    typedef struct packed {
        logic [COUNT_W-1:0] tasks;
        logic [COUNT_W-1:0] escs;
    } bucket_t;

endpackage

// File: rtl/sliding_window_event_counter.sv
// Sliding-window event counter: per-tenant rings of one-second buckets.
// Tenant table and bucket store are on-chip RAMs. Depends on swec_pkg.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+----------------
//  input    | s_operation s_tenant s_now_seconds s_duration  | s_valid/s_ready
//  result   | m_task_sum m_esc_sum                           | m_valid/m_ready
//
// One item at a time through a sequencer around two registered-read RAMs:
// the tenant lookup, then the clear of the buckets in the gap (WINDOW_BUCKETS
// on a first touch or long gap), then a read-modify-write for a record or a
// newest-first walk of min(duration, WINDOW_BUCKETS) buckets for a query, then
// the post. An out-of-range query goes straight to the post, an ignored item
// back to idle. The bucket RAM port, one word per cycle, paces clear and sum.
// Reset clears the valid bits and control state; the RAMs need no sweep.
// s_ready is high only in idle; a query waits before posting while the
// result register still holds an untaken result.
module sliding_window_event_counter
    import swec_pkg::*;
#(
    parameter int NUM_TENANTS    = 128,
    parameter int WINDOW_BUCKETS = 60
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [TENANT_W-1:0] s_tenant,
    input  logic [31:0]         s_now_seconds,
    input  logic [15:0]         s_duration,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COUNT_W-1:0]  m_task_sum,
    output logic [COUNT_W-1:0]  m_esc_sum
);

    localparam int TEN_DEPTH = (NUM_TENANTS < TENANT_SPAN) ? NUM_TENANTS : TENANT_SPAN;
    localparam int TEN_AW    = (TEN_DEPTH > 1) ? $clog2(TEN_DEPTH) : 1;
    localparam int POS_W     = $clog2(WINDOW_BUCKETS);
    localparam int CNT_W     = $clog2(WINDOW_BUCKETS + 1);
    localparam int BKT_DEPTH = TEN_DEPTH * WINDOW_BUCKETS;
    localparam int BKT_AW    = $clog2(BKT_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_BUCKETS - 1);
    localparam logic [POS_W:0]   POS_WRAP = (POS_W + 1)'(WINDOW_BUCKETS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_BUCKETS);

    typedef struct packed {
        logic [31:0]      last;
        logic [POS_W-1:0] pos;
    } meta_t;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_TREAD  = 9'b000000010,
        ST_TGAP   = 9'b000000100,
        ST_TDEC   = 9'b000001000,
        ST_CLEAR  = 9'b000010000,
        ST_RMW_RD = 9'b000100000,
        ST_RMW_WR = 9'b001000000,
        ST_SUM    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    function automatic logic [POS_W-1:0] inc_wrap(input logic [POS_W-1:0] v);
        inc_wrap = (v == POS_LAST) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] dec_wrap(input logic [POS_W-1:0] v);
        dec_wrap = (v == '0) ? POS_LAST : v - 1'b1;
    endfunction

    // storage
    meta_t   meta_mem [TEN_DEPTH];
    bucket_t bkt_mem  [BKT_DEPTH];

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [TENANT_W-1:0]  t_reg, t_next;
    logic [31:0]          now_reg, now_next;
    logic [15:0]          dur_reg, dur_next;
    logic [BKT_AW-1:0]    base_reg, base_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [31:0]          gap_reg, gap_next;
    logic [POS_W-1:0]     walk_idx_reg, walk_idx_next;
    logic [CNT_W-1:0]     walk_left_reg, walk_left_next;
    logic                 pend_reg, pend_next;
    logic [COUNT_W-1:0]   acc_task_reg, acc_task_next;
    logic [COUNT_W-1:0]   acc_esc_reg, acc_esc_next;
    logic                 m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]   m_tasks_reg, m_tasks_next;
    logic [COUNT_W-1:0]   m_escs_reg, m_escs_next;
    logic [TEN_DEPTH-1:0] valid_reg, valid_next;

    meta_t                meta_rd_reg;
    bucket_t              bkt_rd_reg;

    logic [TEN_AW-1:0]    t_idx;
    logic                 meta_we;
    meta_t                meta_wdata;
    logic                 bkt_we;
    logic [BKT_AW-1:0]    bkt_waddr;
    bucket_t              bkt_wdata;
    logic [BKT_AW-1:0]    bkt_raddr;

    logic                 in_range;
    logic                 full_clear;
    logic [POS_W:0]       pos_sum;
    logic [POS_W:0]       pos_adv;
    logic [CNT_W-1:0]     sum_limit;

    assign t_idx     = t_reg[TEN_AW-1:0];
    assign in_range  = 32'(s_tenant) < NUM_TENANTS;
    assign bkt_raddr = base_reg + BKT_AW'((state_reg == ST_SUM) ? walk_idx_reg : pos_reg);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_task_sum = m_tasks_reg;
    assign m_esc_sum  = m_escs_reg;

    always_comb begin
        full_clear = !valid_reg[t_idx] || (gap_reg >= 32'(WINDOW_BUCKETS));
        pos_sum    = {1'b0, pos_reg} + {1'b0, gap_reg[POS_W-1:0]};
        pos_adv    = (pos_sum >= POS_WRAP) ? pos_sum - POS_WRAP : pos_sum;
        sum_limit  = (dur_reg >= 16'(WINDOW_BUCKETS)) ? CNT_FULL : dur_reg[CNT_W-1:0];
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        t_next         = t_reg;
        now_next       = now_reg;
        dur_next       = dur_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        gap_next       = gap_reg;
        walk_idx_next  = walk_idx_reg;
        walk_left_next = walk_left_reg;
        pend_next      = pend_reg;
        acc_task_next  = acc_task_reg;
        acc_esc_next   = acc_esc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_tasks_next   = m_tasks_reg;
        m_escs_next    = m_escs_reg;
        valid_next     = valid_reg;
        meta_we        = 1'b0;
        meta_wdata     = '{last: now_reg, pos: pos_reg};
        bkt_we         = 1'b0;
        bkt_waddr      = base_reg + BKT_AW'(pos_reg);
        bkt_wdata      = bkt_rd_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = op_t'(s_operation);
                    t_next        = s_tenant;
                    now_next      = s_now_seconds;
                    dur_next      = s_duration;
                    base_next     = BKT_AW'(32'(s_tenant) * WINDOW_BUCKETS);
                    acc_task_next = '0;
                    acc_esc_next  = '0;
                    if (op_t'(s_operation) != OP_UNUSED) begin
                        if (in_range) begin
                            state_next = ST_TREAD;
                        end else if (op_t'(s_operation) == OP_QUERY) begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_TREAD: begin
                state_next = ST_TGAP;
            end
            ST_TGAP: begin
                gap_next   = now_reg - meta_rd_reg.last;
                pos_next   = meta_rd_reg.pos;
                state_next = ST_TDEC;
            end
            ST_TDEC: begin
                if (full_clear) begin
                    pos_next       = '0;
                    walk_idx_next  = '0;
                    walk_left_next = CNT_FULL;
                end else begin
                    // zero gap leaves nothing to clear and the position as it was
                    pos_next       = pos_adv[POS_W-1:0];
                    walk_idx_next  = inc_wrap(pos_reg);
                    walk_left_next = gap_reg[CNT_W-1:0];
                end
                meta_we           = 1'b1;
                meta_wdata        = '{last: now_reg, pos: pos_next};
                valid_next[t_idx] = 1'b1;
                state_next        = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (walk_left_reg != '0) begin
                    bkt_we         = 1'b1;
                    bkt_waddr      = base_reg + BKT_AW'(walk_idx_reg);
                    bkt_wdata      = '0;
                    walk_idx_next  = inc_wrap(walk_idx_reg);
                    walk_left_next = walk_left_reg - 1'b1;
                end else begin
                    unique case (op_reg)
                        OP_TASK, OP_ESC: state_next = ST_RMW_RD;
                        OP_QUERY: begin
                            walk_idx_next  = pos_reg;
                            walk_left_next = sum_limit;
                            pend_next      = 1'b0;
                            state_next     = ST_SUM;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RMW_RD: begin
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                bkt_we = 1'b1;
                if (op_reg == OP_TASK) begin
                    bkt_wdata.tasks = bkt_rd_reg.tasks + 1'b1;
                end else begin
                    bkt_wdata.escs = bkt_rd_reg.escs + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SUM: begin
                // reads issued newest first; data lands in the next cycle
                if (pend_reg) begin
                    acc_task_next = acc_task_reg + bkt_rd_reg.tasks;
                    acc_esc_next  = acc_esc_reg + bkt_rd_reg.escs;
                end
                if (walk_left_reg != '0) begin
                    pend_next      = 1'b1;
                    walk_idx_next  = dec_wrap(walk_idx_reg);
                    walk_left_next = walk_left_reg - 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_tasks_next = acc_task_reg;
                    m_escs_next  = acc_esc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        t_reg         <= t_next;
        now_reg       <= now_next;
        dur_reg       <= dur_next;
        base_reg      <= base_next;
        pos_reg       <= pos_next;
        gap_reg       <= gap_next;
        walk_idx_reg  <= walk_idx_next;
        walk_left_reg <= walk_left_next;
        acc_task_reg  <= acc_task_next;
        acc_esc_reg   <= acc_esc_next;
        m_tasks_reg   <= m_tasks_next;
        m_escs_reg    <= m_escs_next;
    end

    // tenant table RAM
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[t_idx] <= meta_wdata;
        end
        meta_rd_reg <= meta_mem[t_idx];
    end

    // bucket RAM
    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        bkt_rd_reg <= bkt_mem[bkt_raddr];
    end

    // checks
    a_sum_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> !bkt_we)
        else $error("bucket write during summation");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("result posted over an untaken result");

    a_tenant_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TDEC) |=> valid_reg[t_idx])
        else $error("tenant not marked valid after lookup");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR || state_reg == ST_SUM) |-> (walk_left_reg <= CNT_FULL))
        else $error("bucket walk count beyond window");

endmodule
